[rtl/gnss_binary_frame_receiver_top_assert.svh]
// Assertion macros shared by the checkers of the binary frame receiver.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef GNSS_BINARY_FRAME_RECEIVER_TOP_ASSERT_SVH
`define GNSS_BINARY_FRAME_RECEIVER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gbfr checker: same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define GBFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gbfr checker: next-cycle implication violated");

`endif

[rtl/gbfr_pkg.sv]
// Package for the binary frame receiver: constants, phase and result codes,
// and the structs passed between the front queue and the parser back end.
// No dependencies.
package gbfr_pkg;

  localparam logic [7:0]  SyncFirst     = 8'hB5;
  localparam logic [7:0]  SyncSecond    = 8'h62;
  localparam int unsigned HeaderBytes   = 6;
  localparam int unsigned FrameOverhead = 8;
  localparam int unsigned MaxFrameBytes = 1024;
  localparam int unsigned QueueDepth    = 4;

  // Positions of the header bytes, counted from the first sync byte.
  localparam logic [15:0] PosClass   = 16'd2;
  localparam logic [15:0] PosId      = 16'd3;
  localparam logic [15:0] PosLenLow  = 16'd4;

  typedef enum logic [2:0] {
    PhSync1   = 3'd0,
    PhSync2   = 3'd1,
    PhHeader  = 3'd2,
    PhPayload = 3'd3,
    PhCheckA  = 3'd4,
    PhCheckB  = 3'd5
  } gbfr_phase_e;

  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindGood     = 2'd1,
    KindChkError = 2'd2,
    KindOverflow = 2'd3
  } gbfr_kind_e;

  // One received byte with its sync classification done up front.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_sync1;
    logic       is_sync2;
  } gbfr_item_t;

  // Handshake group from the front queue to the back end.
  typedef struct packed {
    logic       valid;
    gbfr_item_t item;
  } gbfr_qif_t;

  typedef struct packed {
    gbfr_kind_e  kind;
    logic [7:0]  data_byte;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] decl_length;
    logic [15:0] payload_index;
  } gbfr_result_t;

endpackage

[rtl/gnss_binary_frame_receiver_top.sv]
// Top level of the binary GNSS frame receiver (sync, header, payload, Fletcher check).
// Instantiates gbfr_front and gbfr_back; uses gbfr_pkg.
//
// This block takes one received serial byte per transaction and looks for
// frames that open with the sync pair 0xB5 0x62, followed by class, id, a
// little-endian 16-bit payload length, the payload, and two 8-bit Fletcher
// check bytes computed over class through payload. Each payload byte comes
// out as its own result transaction together with the frame's class, id,
// declared length and the byte's position; the frame then closes with a
// frame-good or checksum-error result, and the receiver goes back to hunting
// for sync by itself. A frame whose declared length plus eight bytes of
// overhead exceeds MaxFrameBytes yields one overflow-abort result instead of
// any payload, and a zero-length frame goes straight to its check bytes.
// Both sides behave as queues: push a byte while full is low, and pop a
// result while empty is low. One byte is taken every cycle for as long as
// results are popped at the same pace; the parser state machine handles a
// byte per cycle, and the input queue (QDepth bytes) and a two-entry result
// queue let the sender and the consumer stall independently. A byte pushed
// is stored in the input queue, and the result it produces, if any, is
// registered in the result queue before it appears at the outputs.
module gnss_binary_frame_receiver_top #(
  parameter int unsigned QDepth = gbfr_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic [7:0]  rx_byte_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  output logic [15:0] decl_length_o,
  output logic [15:0] payload_index_o
);
  import gbfr_pkg::*;

  // Tagged bytes travel from the front queue to the parser through q.
  gbfr_qif_t    q;
  logic         take;
  gbfr_result_t res;

  gbfr_front #(
    .Depth(QDepth)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rx_byte_i(rx_byte_i),
    .full_o   (full),
    .q_o      (q),
    .take_i   (take)
  );

  // The back end runs the frame state machine and owns the result queue.
  gbfr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q),
    .take_o (take),
    .empty_o(empty),
    .pop_i  (pop),
    .res_o  (res)
  );

  assign result_kind_o   = res.kind;
  assign data_byte_o     = res.data_byte;
  assign msg_class_o     = res.msg_class;
  assign msg_id_o        = res.msg_id;
  assign decl_length_o   = res.decl_length;
  assign payload_index_o = res.payload_index;

endmodule

[rtl/gbfr_front.sv]
// Front end of the binary frame receiver: takes received bytes, tags the
// sync bytes and holds them in a short queue for the parser. Uses gbfr_pkg.
module gbfr_front #(
  parameter int unsigned Depth = gbfr_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          rx_byte_i,
  output logic                full_o,
  output gbfr_pkg::gbfr_qif_t q_o,
  input  logic                take_i
);
  import gbfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gbfr_item_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_take;
  gbfr_item_t        new_item;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign do_push  = push_i && !full_o;
  assign do_take  = take_i && (cnt_q != '0);

  assign new_item.rx_byte  = rx_byte_i;
  assign new_item.is_sync1 = (rx_byte_i == SyncFirst);
  assign new_item.is_sync2 = (rx_byte_i == SyncSecond);

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_take) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_take})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

[rtl/gbfr_back.sv]
// Back end of the binary frame receiver: the frame parser state machine with
// its Fletcher sums, and a two-entry result queue. Uses gbfr_pkg.
module gbfr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gbfr_pkg::gbfr_qif_t    q_i,
  output logic                   take_o,
  output logic                   empty_o,
  input  logic                   pop_i,
  output gbfr_pkg::gbfr_result_t res_o
);
  import gbfr_pkg::*;

  gbfr_phase_e  phase_q, phase_d;
  logic [15:0]  cnt_q, cnt_d;
  logic [15:0]  len_q, len_d;
  logic [7:0]   sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]   cls_q, cls_d, id_q, id_d, chk_a_q, chk_a_d;

  logic [7:0]   b;
  logic [15:0]  len_full, cnt_inc;
  logic [7:0]   sum_a_nx, sum_b_nx;
  logic         overflow, pay_last;
  logic         res_valid;
  gbfr_result_t res;

  // Result queue, two entries.
  gbfr_result_t oq_q [2];
  logic         owr_q, ord_q;
  logic [1:0]   ocnt_q, ocnt_d;
  logic         emit, opop;

  assign take_o  = q_i.valid && (ocnt_q != 2'd2);
  assign b       = q_i.item.rx_byte;

  assign len_full = {b, len_q[7:0]};
  assign cnt_inc  = cnt_q + 16'd1;
  assign sum_a_nx = sum_a_q + b;
  assign sum_b_nx = sum_b_q + sum_a_nx;
  assign overflow = (17'(len_full) + 17'(FrameOverhead)) > 17'(MaxFrameBytes);
  assign pay_last = 17'(cnt_inc) >= (17'(len_q) + 17'(HeaderBytes));

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (take_o) begin
      unique case (phase_q)
        PhSync1:   phase_d = q_i.item.is_sync1 ? PhSync2 : PhSync1;
        PhSync2:   phase_d = q_i.item.is_sync2 ? PhHeader : PhSync1;
        PhHeader: begin
          if (cnt_q != PosClass && cnt_q != PosId && cnt_q != PosLenLow) begin
            if (overflow) begin
              phase_d = PhSync1;
            end else begin
              phase_d = (len_full == 16'd0) ? PhCheckA : PhPayload;
            end
          end
        end
        PhPayload: phase_d = pay_last ? PhCheckA : PhPayload;
        PhCheckA:  phase_d = PhCheckB;
        PhCheckB:  phase_d = PhSync1;
        default:   phase_d = PhSync1;
      endcase
    end
  end

  // Frame bookkeeping registers.
  always_comb begin
    cnt_d   = cnt_q;
    len_d   = len_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    cls_d   = cls_q;
    id_d    = id_q;
    chk_a_d = chk_a_q;
    if (take_o) begin
      unique case (phase_q)
        PhSync1: cnt_d = q_i.item.is_sync1 ? 16'd1 : 16'd0;
        PhSync2: begin
          if (q_i.item.is_sync2) begin
            cnt_d   = 16'd2;
            sum_a_d = '0;
            sum_b_d = '0;
          end else begin
            cnt_d = 16'd0;
          end
        end
        PhHeader: begin
          sum_a_d = sum_a_nx;
          sum_b_d = sum_b_nx;
          cnt_d   = cnt_inc;
          priority if (cnt_q == PosClass) begin
            cls_d = b;
          end else if (cnt_q == PosId) begin
            id_d = b;
          end else if (cnt_q == PosLenLow) begin
            len_d = {8'h00, b};
          end else begin
            len_d = len_full;
            cnt_d = overflow ? 16'd0 : 16'(HeaderBytes);
          end
        end
        PhPayload: begin
          sum_a_d = sum_a_nx;
          sum_b_d = sum_b_nx;
          cnt_d   = cnt_inc;
        end
        PhCheckA: begin
          chk_a_d = b;
          cnt_d   = cnt_inc;
        end
        default: cnt_d = 16'd0;
      endcase
    end
  end

  // Result produced by the byte being taken.
  always_comb begin
    res_valid         = 1'b0;
    res.kind          = KindPayload;
    res.data_byte     = '0;
    res.msg_class     = cls_q;
    res.msg_id        = id_q;
    res.decl_length   = len_q;
    res.payload_index = '0;
    unique case (phase_q)
      PhHeader: begin
        if (cnt_q != PosClass && cnt_q != PosId && cnt_q != PosLenLow && overflow) begin
          res_valid       = 1'b1;
          res.kind        = KindOverflow;
          res.decl_length = len_full;
        end
      end
      PhPayload: begin
        res_valid         = 1'b1;
        res.data_byte     = b;
        res.payload_index = cnt_q - 16'(HeaderBytes);
      end
      PhCheckB: begin
        res_valid = 1'b1;
        res.kind  = (chk_a_q == sum_a_q && b == sum_b_q) ? KindGood : KindChkError;
      end
      default: res_valid = 1'b0;
    endcase
  end

  assign emit    = take_o && res_valid;
  assign empty_o = (ocnt_q == 2'd0);
  assign opop    = pop_i && !empty_o;
  assign res_o   = oq_q[ord_q];

  always_comb begin
    unique case ({emit, opop})
      2'b10:   ocnt_d = ocnt_q + 2'd1;
      2'b01:   ocnt_d = ocnt_q - 2'd1;
      default: ocnt_d = ocnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSync1;
      cnt_q   <= '0;
      len_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      cls_q   <= '0;
      id_q    <= '0;
      chk_a_q <= '0;
      owr_q   <= 1'b0;
      ord_q   <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      cls_q   <= cls_d;
      id_q    <= id_d;
      chk_a_q <= chk_a_d;
      owr_q   <= owr_q ^ emit;
      ord_q   <= ord_q ^ opop;
      ocnt_q  <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      oq_q[owr_q] <= res;
    end
  end

endmodule

[rtl/gbfr_checker.sv]
// Port-level checker for the binary frame receiver, bound to the top level.
// Uses gbfr_pkg and the assertion macros in gnss_binary_frame_receiver_top_assert.svh.
`include "gnss_binary_frame_receiver_top_assert.svh"

module gbfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  result_kind_o,
  input logic [7:0]  data_byte_o,
  input logic [15:0] decl_length_o,
  input logic [15:0] payload_index_o
);
  import gbfr_pkg::*;

  logic zero_fields;
  logic index_ok;
  logic fits_buffer;

  assign zero_fields = (data_byte_o == 8'd0) && (payload_index_o == 16'd0);
  assign index_ok    = (payload_index_o < decl_length_o);
  assign fits_buffer = (17'(decl_length_o) + 17'(FrameOverhead)) <= 17'(MaxFrameBytes);

  // A waiting result must not vanish without being popped.
  `GBFR_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)

  // Only payload results carry a data byte and a position.
  `GBFR_ASSERT_IMPL(a_non_payload_zero, !empty && result_kind_o != KindPayload, zero_fields)

  // A payload byte always lies inside the declared payload.
  `GBFR_ASSERT_IMPL(a_index_in_range, !empty && result_kind_o == KindPayload, index_ok)

  // Every result other than an abort belongs to a frame that fits the buffer.
  `GBFR_ASSERT_IMPL(a_frame_fits, !empty && result_kind_o != KindOverflow, fits_buffer)

endmodule

bind gnss_binary_frame_receiver_top gbfr_checker u_gbfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .result_kind_o  (result_kind_o),
  .data_byte_o    (data_byte_o),
  .decl_length_o  (decl_length_o),
  .payload_index_o(payload_index_o)
);

[bench/tb_gnss_binary_frame_receiver_top.sv]
// Self-checking testbench for gnss_binary_frame_receiver_top: directed frames, then random
// frames, noise and broken sequences, with every result checked against a local parser model.
// Depends on gbfr_pkg and the receiver RTL only.
`timescale 1ns / 100ps

module tb_gnss_binary_frame_receiver_top;
  import gbfr_pkg::*;

  // Watchdog limit on cycles in which neither side completes a transaction.
  localparam int unsigned WatchdogLimit = 5000;
  // Long receiver hold-off that lets the byte and result queues fill up.
  localparam int unsigned LongHold      = 60;
  // Cycles allowed after the last expected result for stray results to show up.
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned TargetBytes   = 1900;
  // Past this many bytes the sender and the receiver stop idling.
  localparam int unsigned CalmAfter     = 1650;
  localparam int unsigned DirectedCount = 26;
  localparam int unsigned MaxPayload    = MaxFrameBytes - FrameOverhead;

  // One row of the directed table. When typed is set, the row itself says whether
  // a result follows and of what kind; otherwise the parser model decides.
  typedef struct packed {
    logic [7:0] rx_byte;
    bit         typed;
    bit         has_result;
    gbfr_kind_e kind;
  } byte_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  result_kind_o;
  logic [7:0]  data_byte_o;
  logic [7:0]  msg_class_o;
  logic [7:0]  msg_id_o;
  logic [15:0] decl_length_o;
  logic [15:0] payload_index_o;

  // Results that the parser model has predicted and the block has not yet delivered.
  gbfr_result_t pending_results [$];
  byte_row_t    directed_rows [DirectedCount];

  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;
  // Set by the sender to ask the receiver for one long hold-off.
  bit          hold_request = 1'b0;

  // Parser model state, kept in step with the block one accepted byte at a time.
  gbfr_phase_e rx_phase = PhSync1;
  logic [15:0] rx_count = '0;
  logic [15:0] frame_len = '0;
  logic [7:0]  fletcher_a = '0;
  logic [7:0]  fletcher_b = '0;
  logic [7:0]  frame_cls = '0;
  logic [7:0]  frame_mid = '0;
  logic [7:0]  check_a_seen = '0;

  gnss_binary_frame_receiver_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .rx_byte_i        (rx_byte_i),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .result_kind_o    (result_kind_o),
    .data_byte_o      (data_byte_o),
    .msg_class_o      (msg_class_o),
    .msg_id_o         (msg_id_o),
    .decl_length_o    (decl_length_o),
    .payload_index_o  (payload_index_o)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Builds a result from the current frame header. Data and index are only
  // meaningful for payload bytes and are zero for the closing results.
  function automatic gbfr_result_t frame_result(input gbfr_kind_e kind, input logic [7:0] data,
                                                input logic [15:0] index);
    gbfr_result_t res;
    res.kind          = kind;
    res.data_byte     = data;
    res.msg_class     = frame_cls;
    res.msg_id        = frame_mid;
    res.decl_length   = frame_len;
    res.payload_index = index;
    return res;
  endfunction

  // Parser model: advances the frame state by one received byte and reports
  // the result that byte causes, if any.
  task automatic parse_byte(input logic [7:0] b, output bit produced, output gbfr_result_t res);
    int unsigned frame_total;
    produced = 1'b0;
    res = '0;
    case (rx_phase)
      PhSync1: begin
        if (b == SyncFirst) begin
          rx_phase = PhSync2;
          rx_count = 16'd1;
        end else begin
          rx_count = '0;
        end
      end
      PhSync2: begin
        // A wrong second sync byte is dropped, not retried as a first sync byte.
        if (b == SyncSecond) begin
          rx_phase   = PhHeader;
          rx_count   = 16'd2;
          fletcher_a = '0;
          fletcher_b = '0;
        end else begin
          rx_phase = PhSync1;
          rx_count = '0;
        end
      end
      PhHeader: begin
        fletcher_a = fletcher_a + b;
        fletcher_b = fletcher_b + fletcher_a;
        if (rx_count == PosClass) begin
          frame_cls = b;
          rx_count  = rx_count + 16'd1;
        end else if (rx_count == PosId) begin
          frame_mid = b;
          rx_count  = rx_count + 16'd1;
        end else if (rx_count == PosLenLow) begin
          frame_len = {8'h00, b};
          rx_count  = rx_count + 16'd1;
        end else begin
          frame_len   = {b, frame_len[7:0]};
          frame_total = int'(frame_len) + FrameOverhead;
          if (frame_total > MaxFrameBytes) begin
            // Oversized frame: one abort result and back to hunting.
            produced = 1'b1;
            res      = frame_result(KindOverflow, 8'h00, 16'h0000);
            rx_phase = PhSync1;
            rx_count = '0;
          end else begin
            rx_count = 16'(HeaderBytes);
            // An empty payload skips straight to the check bytes.
            rx_phase = (frame_len == 16'h0000) ? PhCheckA : PhPayload;
          end
        end
      end
      PhPayload: begin
        fletcher_a = fletcher_a + b;
        fletcher_b = fletcher_b + fletcher_a;
        produced   = 1'b1;
        res        = frame_result(KindPayload, b, rx_count - 16'(HeaderBytes));
        rx_count   = rx_count + 16'd1;
        if (int'(rx_count) >= int'(frame_len) + HeaderBytes) begin
          rx_phase = PhCheckA;
        end
      end
      PhCheckA: begin
        check_a_seen = b;
        rx_count     = rx_count + 16'd1;
        rx_phase     = PhCheckB;
      end
      PhCheckB: begin
        produced = 1'b1;
        if (check_a_seen == fletcher_a && b == fletcher_b) begin
          res = frame_result(KindGood, 8'h00, 16'h0000);
        end else begin
          res = frame_result(KindChkError, 8'h00, 16'h0000);
        end
        rx_phase = PhSync1;
        rx_count = '0;
      end
      default: begin
        rx_phase = PhSync1;
        rx_count = '0;
      end
    endcase
  endtask

  // Offers one byte, starting at a falling edge, and returns at the falling edge
  // after the transaction. A typed row overrides the model's verdict on whether
  // a result follows and of what kind.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit typed_has = 1'b0, input gbfr_kind_e typed_kind = KindPayload);
    bit           produced;
    gbfr_result_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    parse_byte(b, produced, res);
    if (typed) begin
      if (typed_has) begin
        res.kind = typed_kind;
        pending_results.push_back(res);
      end
    end else if (produced) begin
      pending_results.push_back(res);
    end
    @(negedge clk_i);
  endtask

  // Sends a complete frame with random class, id and payload. When corrupt is
  // set, one bit of one check byte is flipped.
  task automatic send_frame(input int unsigned len, input bit corrupt);
    logic [7:0] body [$];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    body = {};
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    repeat (len) body.push_back(8'($urandom_range(0, 255)));
    ck_a = '0;
    ck_b = '0;
    foreach (body[i]) begin
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end
    if (corrupt) begin
      if ($urandom_range(0, 1) == 1) begin
        ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
      end else begin
        ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    foreach (body[i]) send_byte(body[i]);
    send_byte(ck_a);
    send_byte(ck_b);
  endtask

  // Stops offering bytes until every predicted result has been delivered.
  task automatic drain_results();
    push <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk_i);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Result monitor and watchdog. Every delivered result is matched against the
  // oldest prediction, field by field.
  always @(posedge clk_i) begin
    gbfr_result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result, expected none, actual kind %0d data 0x%0h index %0d",
                 $time, result_kind_o, data_byte_o, payload_index_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("result_kind", want.kind, result_kind_o);
        compare_field("data_byte", want.data_byte, data_byte_o);
        compare_field("msg_class", want.msg_class, msg_class_o);
        compare_field("msg_id", want.msg_id, msg_id_o);
        compare_field("decl_length", want.decl_length, decl_length_o);
        compare_field("payload_index", want.payload_index, payload_index_o);
      end
    end
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: pops freely, with short random hold-offs while idling is on, and
  // one long hold-off when the sender asks for it.
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // Sender: reset, the directed table, then random traffic.
  initial begin
    int unsigned pick;
    int unsigned len;

    // Directed rows: an idle byte after reset, a broken sync pair, a zero-length
    // frame with a good checksum, a frame one byte too long for the buffer, and
    // a one-byte frame with a bad second check byte.
    directed_rows = '{
      '{8'h00, 1'b1, 1'b0, KindPayload},
      '{8'hB5, 1'b1, 1'b0, KindPayload},
      '{8'h00, 1'b1, 1'b0, KindPayload},
      '{8'hB5, 1'b1, 1'b0, KindPayload},
      '{8'h62, 1'b1, 1'b0, KindPayload},
      '{8'hFF, 1'b1, 1'b0, KindPayload},
      '{8'h00, 1'b1, 1'b0, KindPayload},
      '{8'h00, 1'b1, 1'b0, KindPayload},
      '{8'h00, 1'b1, 1'b0, KindPayload},
      '{8'hFF, 1'b1, 1'b0, KindPayload},
      '{8'hFC, 1'b1, 1'b1, KindGood},
      '{8'hB5, 1'b0, 1'b0, KindPayload},
      '{8'h62, 1'b0, 1'b0, KindPayload},
      '{8'h01, 1'b0, 1'b0, KindPayload},
      '{8'h02, 1'b0, 1'b0, KindPayload},
      '{8'hF9, 1'b0, 1'b0, KindPayload},
      '{8'h03, 1'b1, 1'b1, KindOverflow},
      '{8'hB5, 1'b0, 1'b0, KindPayload},
      '{8'h62, 1'b0, 1'b0, KindPayload},
      '{8'h00, 1'b0, 1'b0, KindPayload},
      '{8'h00, 1'b0, 1'b0, KindPayload},
      '{8'h01, 1'b0, 1'b0, KindPayload},
      '{8'h00, 1'b0, 1'b0, KindPayload},
      '{8'hFF, 1'b0, 1'b0, KindPayload},
      '{8'h00, 1'b0, 1'b0, KindPayload},
      '{8'h00, 1'b1, 1'b1, KindChkError}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                directed_rows[i].has_result, directed_rows[i].kind);
    end

    // The sender holds back once until the directed results are all out.
    drain_results();

    // The largest frame that fits, with the receiver holding off at its start,
    // so that both queues fill and the input stalls while bytes are offered.
    hold_request = 1'b1;
    send_frame(MaxPayload, 1'b0);
    drain_results();

    // Random part: mostly well-formed frames with short payloads, plus bad
    // checksums, oversized headers, truncated frames and line noise.
    while (bytes_sent < TargetBytes) begin
      if (bytes_sent >= CalmAfter) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
        send_frame(len, $urandom_range(0, 6) == 0);
      end else if (pick < 75) begin
        send_frame($urandom_range(0, 8), 1'b1);
      end else if (pick < 82) begin
        // Header whose declared length is too large for the buffer.
        len = $urandom_range(MaxPayload + 1, 65535);
        send_byte(SyncFirst);
        send_byte(SyncSecond);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(len[7:0]);
        send_byte(len[15:8]);
      end else if (pick < 90) begin
        // Frame cut short; whatever follows is taken as the rest of it.
        send_byte(SyncFirst);
        if ($urandom_range(0, 2) == 0) begin
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(SyncSecond);
          repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    // Let every predicted result arrive, then watch a little longer for strays.
    push <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
